// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/msss_pkg.sv
package msss_pkg;

   localparam int FUNC_W   = 2;
   localparam int SEL_W    = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int DEPTH_W  = 7;
   localparam int NSTK_W   = 4;
   localparam int CSR_W    = 32;
   localparam int CSR_AW   = 3;

   localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_STACK = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   localparam logic [CSR_AW-1:0] REG_NUM_STACKS = 3'd0;

   typedef struct packed {
      logic             en;
      logic             dec;
      logic [SEL_W-1:0] sel;
   } ptr_cmd_type;

endpackage

// File: rtl/msss_ifs.sv
interface msss_req_if;
   import msss_pkg::*;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [SEL_W-1:0]  stack_sel;
   logic [DATA_W-1:0] push_value;
   modport source (output valid, func, stack_sel, push_value, input ready);
   modport sink (input valid, func, stack_sel, push_value, output ready);
endinterface

interface msss_rsp_if;
   import msss_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   read_value;
   logic [STATUS_W-1:0] status;
   logic [DEPTH_W-1:0]  stack_depth;
   modport source (output valid, read_value, status, stack_depth, input ready);
   modport sink (input valid, read_value, status, stack_depth, output ready);
endinterface

// File: rtl/msss_ram.sv
module msss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/msss_ptr_file.sv
module msss_ptr_file #(
   parameter int MAX_STACKS = 8,
   parameter int PTR_W      = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [msss_pkg::SEL_W-1:0] rd_idx,
   output logic [PTR_W-1:0]          rd_val,
   output logic [PTR_W-1:0]          total,
   input  msss_pkg::ptr_cmd_type     cmd
);
   import msss_pkg::*;

   logic [PTR_W-1:0] ptr_ff [MAX_STACKS];
   logic [PTR_W-1:0] ptr_in [MAX_STACKS];

   always_comb begin
      rd_val = '0;
      for (int k = 0; k < MAX_STACKS; k++) begin
         if (k == int'(rd_idx)) begin
            rd_val = ptr_ff[k];
         end
      end
   end

   assign total = ptr_ff[MAX_STACKS-1];

   always_comb begin
      for (int k = 0; k < MAX_STACKS; k++) begin
         ptr_in[k] = ptr_ff[k];
         if (cmd.en && k >= int'(cmd.sel)) begin
            ptr_in[k] = cmd.dec ? ptr_ff[k] - 1'b1 : ptr_ff[k] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_STACKS; k++) begin
         if (reset) begin
            ptr_ff[k] <= '0;
         end else begin
            ptr_ff[k] <= ptr_in[k];
         end
      end
   end

endmodule

// File: rtl/multi_stack_shared_store_unit.sv
// Several stacks share one value store; each stack ends where its end pointer says. One
// request at a time: a push moves every entry above the insertion point up one place, a pop
// moves every entry above the removed top down one place, one entry per cycle through the
// single-write-port value store. An accepted request passes S_BASE, then S_TOP for a pop or
// peek, S_SHIFT and S_DRAIN when entries move, and S_FILL for a push, then S_DONE presents the
// response. An empty stack, full store or unused code goes from S_BASE to S_DONE, a bad stack
// number straight to S_DONE; S_DONE waits while an earlier response is not yet taken. A
// finished response waits in its output register while the next request is taken.
`include "assert_macros.svh"

module multi_stack_shared_store_unit #(
   parameter int CAPACITY   = 64,
   parameter int MAX_STACKS = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   msss_req_if.sink                    req_bus,
   msss_rsp_if.source                  rsp_bus,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [msss_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [msss_pkg::CSR_W-1:0]  csr_pwdata,
   output logic [msss_pkg::CSR_W-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import msss_pkg::*;

   localparam int PTR_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_BASE  = 7'b0000010,
      S_TOP   = 7'b0000100,
      S_SHIFT = 7'b0001000,
      S_DRAIN = 7'b0010000,
      S_FILL  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [FUNC_W-1:0]      func_ff, func_in;
   logic [SEL_W-1:0]       sel_ff, sel_in;
   logic [VALUE_BITS-1:0]  pv_ff, pv_in;
   logic [PTR_W-1:0]       end_ff, end_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [ADDR_W-1:0]      stop_ff, stop_in;
   logic [ADDR_W-1:0]      pend_addr_ff, pend_addr_in;
   logic                   pend_ff, pend_in;
   logic                   dir_ff, dir_in;
   logic                   more_ff, more_in;
   logic [VALUE_BITS-1:0]  rv_ff, rv_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [PTR_W-1:0]       depth_ff, depth_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [DEPTH_W-1:0]     rsp_depth_ff, rsp_depth_in;
   logic [NSTK_W-1:0]      num_stacks_ff, num_stacks_in;

   logic                   req_fire;
   logic                   bad_req;
   logic                   csr_write;
   logic [SEL_W-1:0]       ptr_rd_idx;
   logic [PTR_W-1:0]       ptr_rd_val;
   logic [PTR_W-1:0]       ptr_total;
   ptr_cmd_type            ptr_cmd;
   logic [PTR_W-1:0]       base;
   logic [PTR_W-1:0]       depth_cur;
   logic [PTR_W-1:0]       lim;

   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr;
   logic [VALUE_BITS-1:0]  ram_wdata;
   logic                   ram_re;
   logic [ADDR_W-1:0]      ram_raddr;
   logic [VALUE_BITS-1:0]  ram_rdata;

   msss_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   msss_ptr_file #(
      .MAX_STACKS (MAX_STACKS),
      .PTR_W      (PTR_W)
   ) u_ptrs (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (ptr_rd_idx),
      .rd_val (ptr_rd_val),
      .total  (ptr_total),
      .cmd    (ptr_cmd)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? '0 : CSR_W'(num_stacks_ff);
   assign num_stacks_in = csr_write ? csr_pwdata[NSTK_W-1:0] : num_stacks_ff;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign bad_req       = ({1'b0, req_bus.stack_sel} >= num_stacks_ff)
                          || (int'(req_bus.stack_sel) >= MAX_STACKS);

   assign ptr_rd_idx = (state_ff == S_IDLE) ? req_bus.stack_sel : sel_ff - 1'b1;
   assign base       = (sel_ff == '0) ? '0 : ptr_rd_val;
   assign depth_cur  = end_ff - base;
   assign lim        = (ptr_total > PTR_W'(CAPACITY)) ? PTR_W'(CAPACITY) : ptr_total;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.read_value  = rsp_value_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.stack_depth = rsp_depth_ff;

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      sel_in        = sel_ff;
      pv_in         = pv_ff;
      end_in        = end_ff;
      addr_in       = addr_ff;
      stop_in       = stop_ff;
      pend_addr_in  = pend_addr_ff;
      pend_in       = pend_ff;
      dir_in        = dir_ff;
      more_in       = more_ff;
      rv_in         = rv_ff;
      status_in     = status_ff;
      depth_in      = depth_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      ptr_cmd       = '{en: 1'b0, dec: 1'b0, sel: sel_ff};
      ram_we        = 1'b0;
      ram_waddr     = pend_addr_ff;
      ram_wdata     = ram_rdata;
      ram_re        = 1'b0;
      ram_raddr     = addr_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               func_in   = req_bus.func;
               sel_in    = req_bus.stack_sel;
               pv_in     = VALUE_BITS'(req_bus.push_value);
               end_in    = ptr_rd_val;
               rv_in     = '0;
               pend_in   = 1'b0;
               if (bad_req) begin
                  status_in = STATUS_BAD_STACK;
                  depth_in  = '0;
                  state_in  = S_DONE;
               end else begin
                  state_in  = S_BASE;
               end
            end
         end
         S_BASE: begin
            status_in = STATUS_OK;
            depth_in  = depth_cur;
            state_in  = S_DONE;
            if (func_ff == FUNC_PUSH) begin
               if (ptr_total >= PTR_W'(CAPACITY) || end_ff > ptr_total) begin
                  status_in = STATUS_FULL;
               end else begin
                  depth_in = depth_cur + 1'b1;
                  dir_in   = 1'b1;
                  if (ptr_total > end_ff) begin
                     addr_in  = ADDR_W'(ptr_total - 1'b1);
                     stop_in  = ADDR_W'(end_ff);
                     state_in = S_SHIFT;
                  end else begin
                     state_in = S_FILL;
                  end
               end
            end else if (func_ff == FUNC_POP || func_ff == FUNC_PEEK) begin
               if (depth_cur == '0 || end_ff > PTR_W'(CAPACITY)) begin
                  status_in = STATUS_EMPTY;
                  depth_in  = '0;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = ADDR_W'(end_ff - 1'b1);
                  addr_in   = ADDR_W'(end_ff);
                  stop_in   = ADDR_W'(lim - 1'b1);
                  dir_in    = 1'b0;
                  more_in   = end_ff < lim;
                  state_in  = S_TOP;
               end
            end
         end
         S_TOP: begin
            rv_in    = ram_rdata;
            state_in = S_DONE;
            if (func_ff == FUNC_POP) begin
               ptr_cmd  = '{en: 1'b1, dec: 1'b1, sel: sel_ff};
               depth_in = depth_ff - 1'b1;
               if (more_ff) begin
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            ram_re       = 1'b1;
            ram_raddr    = addr_ff;
            ram_we       = pend_ff;
            pend_in      = 1'b1;
            pend_addr_in = dir_ff ? addr_ff + 1'b1 : addr_ff - 1'b1;
            if (addr_ff == stop_ff) begin
               state_in = S_DRAIN;
            end else begin
               addr_in = dir_ff ? addr_ff - 1'b1 : addr_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            ram_we   = 1'b1;
            pend_in  = 1'b0;
            state_in = dir_ff ? S_FILL : S_DONE;
         end
         S_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(end_ff);
            ram_wdata = pv_ff;
            ptr_cmd   = '{en: 1'b1, dec: 1'b0, sel: sel_ff};
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = DATA_W'(rv_ff);
               rsp_status_in = status_ff;
               rsp_depth_in  = DEPTH_W'(depth_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         num_stacks_ff <= NSTK_W'(1);
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         num_stacks_ff <= num_stacks_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      sel_ff        <= sel_in;
      pv_ff         <= pv_in;
      end_ff        <= end_in;
      addr_ff       <= addr_in;
      stop_ff       <= stop_in;
      pend_addr_ff  <= pend_addr_in;
      dir_ff        <= dir_in;
      more_ff       <= more_in;
      rv_ff         <= rv_in;
      status_ff     <= status_in;
      depth_ff      <= depth_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   `ASSERT_SAME(a_no_store_write_idle, clock, reset, state_ff == S_IDLE, !ram_we)
   `ASSERT_SAME(a_total_in_range, clock, reset, 1'b1, ptr_total <= PTR_W'(CAPACITY))
   `ASSERT_NEXT(a_accept_moves_on, clock, reset, req_fire, state_ff == S_BASE || state_ff == S_DONE)
   `ASSERT_SAME(a_ptr_update_states, clock, reset, ptr_cmd.en, state_ff == S_TOP || state_ff == S_FILL)

endmodule
